[hw/rtl/fgs_pkg.sv]
package fgs_pkg;

    localparam int XW      = 32;   // coordinate field width
    localparam int HW      = 16;   // heading field width
    localparam int WW      = 16;   // weight register width
    localparam int ACC_W   = 68;   // multiply-accumulate width
    localparam int SCORE_W = 52;
    localparam int DOT_W   = 50;
    localparam int NORM_W  = 33;
    localparam int COS_W   = 18;
    localparam int QUO_W   = 17;
    localparam int CNT_W   = 6;

    localparam logic [CNT_W-1:0] SQ_BITS = CNT_W'(XW);
    localparam logic [CNT_W-1:0] WT_BITS = CNT_W'(WW);

    // configuration register indexes
    localparam logic [1:0] CFG_DIST_W  = 2'd0;
    localparam logic [1:0] CFG_DIR_W   = 2'd1;
    localparam logic [1:0] CFG_FILT_ON = 2'd2;
    localparam logic [1:0] CFG_TOL     = 2'd3;

    typedef struct packed {
        logic signed [XW-1:0] frontier_x;
        logic signed [XW-1:0] frontier_y;
        logic signed [XW-1:0] robot_x;
        logic signed [XW-1:0] robot_y;
        logic signed [HW-1:0] heading_x;
        logic signed [HW-1:0] heading_y;
        logic                 last_frontier;
    } t_frontier;

    typedef struct packed {
        logic                 goal_found;
        logic signed [XW-1:0] goal_x;
        logic signed [XW-1:0] goal_y;
    } t_goal;

    typedef struct packed {
        logic             go;
        logic             clr;
        logic             neg;
        logic [CNT_W-1:0] nbits;
    } t_mac_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOL,
        ST_FD_X,
        ST_FD_Y,
        ST_FILT,
        ST_D_X,
        ST_D_Y,
        ST_SQRT,
        ST_DOT_X,
        ST_DOT_Y,
        ST_DIV,
        ST_SC_DIR,
        ST_SC_DIST,
        ST_UPD,
        ST_EMIT
    } t_state;

    // magnitude of a 33-bit difference of two 32-bit values
    function automatic logic [XW-1:0] mag33(logic signed [XW:0] v);
        logic signed [XW:0] n;
        n = -v;
        return v[XW] ? n[XW-1:0] : v[XW-1:0];
    endfunction

endpackage

[hw/rtl/fgs_stream_if.sv]
interface fgs_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/frontier_goal_select.sv]
// Exploration goal selector. Frontier points arrive one per transfer; each is
// optionally dropped when it lies inside the tolerance circle around the last
// chosen goal, otherwise scored as heading weight * cos - range weight * dist
// and compared against the best of the batch (earliest wins a tie). The
// transfer flagged last_frontier yields one result and a found goal becomes
// the new last goal. One item is processed at a time; the divide is skipped
// when the point sits on the robot. The work is done by a single shared
// shift-add multiplier working one bit per cycle, a bit-pair serial square
// root and a bit-serial divider. A result waits in an output register and
// the next item is taken while it waits, except on a batch end whose
// predecessor result is still untaken.
module frontier_goal_select #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [fgs_pkg::XW-1:0]  i_cfg_data,
    fgs_stream_if.sink              i_frontier,
    fgs_stream_if.source            o_goal
);
    import fgs_pkg::*;

    localparam int CW_EFF = (COORD_WIDTH > XW) ? XW : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);
    localparam int SH     = XW - CW_EFF;

    // configuration
    logic [WW-1:0]       r_dist_w;
    logic [WW-1:0]       r_dir_w;
    logic                r_filt_on;
    logic [XW-1:0]       r_tol;

    // control
    t_state              r_state, n_state;
    logic                r_run, n_run;
    logic                r_have;
    logic                r_skip;
    logic                r_out_valid;

    // item and working registers
    logic signed [XW-1:0] r_fx, r_fy;
    logic signed [XW:0]   r_dx, r_dy, r_fdx, r_fdy;
    logic signed [HW-1:0] r_hx, r_hy;
    logic                 r_last;
    logic [2*XW-1:0]      r_tolsq;
    logic [NORM_W-1:0]    r_norm;
    logic signed [DOT_W-1:0]  r_dot;
    logic signed [COS_W-1:0]  r_cos;
    logic signed [SCORE_W-1:0] r_score, r_best;
    logic signed [XW-1:0] r_bx, r_by;
    logic signed [XW-1:0] r_prev_x, r_prev_y;
    logic                 r_goal_found;
    logic signed [XW-1:0] r_goal_x, r_goal_y;

    logic signed [XW-1:0] w_fx, w_fy, w_rx, w_ry;
    logic                 w_accept;
    logic                 w_emit_ok;
    logic                 w_skip_now;
    logic                 w_upd_best;

    t_mac_req                w_mac_req;
    logic signed [ACC_W-1:0] w_mac_a;
    logic [XW-1:0]           w_mac_b;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_mac_done;
    logic                    w_sqrt_go, w_sqrt_done;
    logic [NORM_W-1:0]       w_root;
    logic                    w_div_go, w_div_done;
    logic [QUO_W-1:0]        w_quo;
    logic [DOT_W-1:0]        w_dot_mag;
    logic signed [DOT_W-1:0] w_dot_neg;
    logic [HW-1:0]           w_hmag;
    logic signed [HW-1:0]    w_hneg;

    assign w_fx = (i_frontier.data.frontier_x <<< SH) >>> SH;
    assign w_fy = (i_frontier.data.frontier_y <<< SH) >>> SH;
    assign w_rx = (i_frontier.data.robot_x <<< SH) >>> SH;
    assign w_ry = (i_frontier.data.robot_y <<< SH) >>> SH;

    assign w_accept   = i_frontier.valid && i_frontier.ready;
    assign w_emit_ok  = !r_out_valid || o_goal.ready;
    assign w_skip_now = (w_acc[2*XW:0] < {1'b0, r_tolsq});
    assign w_upd_best = !r_skip && (!r_have || (r_score > r_best));
    assign w_dot_neg  = -r_dot;
    assign w_dot_mag  = r_dot[DOT_W-1] ? w_dot_neg : r_dot;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_w  <= WW'(256);
            r_dir_w   <= '0;
            r_filt_on <= 1'b1;
            r_tol     <= XW'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIST_W:  r_dist_w  <= i_cfg_data[WW-1:0];
                CFG_DIR_W:   r_dir_w   <= i_cfg_data[WW-1:0];
                CFG_FILT_ON: r_filt_on <= i_cfg_data[0];
                CFG_TOL:     r_tol     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (w_accept) n_state = r_filt_on ? ST_TOL : ST_D_X;
            ST_TOL:     if (w_mac_done) n_state = ST_FD_X;
            ST_FD_X:    if (w_mac_done) n_state = ST_FD_Y;
            ST_FD_Y:    if (w_mac_done) n_state = ST_FILT;
            ST_FILT:    n_state = w_skip_now ? ST_UPD : ST_D_X;
            ST_D_X:     if (w_mac_done) n_state = ST_D_Y;
            ST_D_Y:     if (w_mac_done) n_state = ST_SQRT;
            ST_SQRT:    if (w_sqrt_done) n_state = ST_DOT_X;
            ST_DOT_X:   if (w_mac_done) n_state = ST_DOT_Y;
            ST_DOT_Y:   if (w_mac_done) n_state = ST_DIV;
            ST_DIV:     if (r_norm == '0 || w_div_done) n_state = ST_SC_DIR;
            ST_SC_DIR:  if (w_mac_done) n_state = ST_SC_DIST;
            ST_SC_DIST: if (w_mac_done) n_state = ST_UPD;
            ST_UPD:     n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT:    if (w_emit_ok) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: unit starts and operands
    always_comb begin
        w_mac_req = '0;
        w_mac_a   = '0;
        w_mac_b   = '0;
        w_sqrt_go = 1'b0;
        w_div_go  = 1'b0;
        w_hneg    = '0;
        w_hmag    = '0;
        i_frontier.ready = (r_state == ST_IDLE);
        case (r_state)
            ST_TOL: begin
                w_mac_req = '{go: !r_run, clr: 1'b1, neg: 1'b0, nbits: SQ_BITS};
                w_mac_a   = ACC_W'(r_tol);
                w_mac_b   = r_tol;
            end
            ST_FD_X: begin
                w_mac_req = '{go: !r_run, clr: 1'b1, neg: r_fdx[XW], nbits: SQ_BITS};
                w_mac_a   = ACC_W'(r_fdx);
                w_mac_b   = mag33(r_fdx);
            end
            ST_FD_Y: begin
                w_mac_req = '{go: !r_run, clr: 1'b0, neg: r_fdy[XW], nbits: SQ_BITS};
                w_mac_a   = ACC_W'(r_fdy);
                w_mac_b   = mag33(r_fdy);
            end
            ST_D_X: begin
                w_mac_req = '{go: !r_run, clr: 1'b1, neg: r_dx[XW], nbits: SQ_BITS};
                w_mac_a   = ACC_W'(r_dx);
                w_mac_b   = mag33(r_dx);
            end
            ST_D_Y: begin
                w_mac_req = '{go: !r_run, clr: 1'b0, neg: r_dy[XW], nbits: SQ_BITS};
                w_mac_a   = ACC_W'(r_dy);
                w_mac_b   = mag33(r_dy);
            end
            ST_SQRT: w_sqrt_go = !r_run;
            ST_DOT_X: begin
                w_hneg    = -r_hx;
                w_hmag    = r_hx[HW-1] ? w_hneg : r_hx;
                w_mac_req = '{go: !r_run, clr: 1'b1, neg: r_hx[HW-1], nbits: WT_BITS};
                w_mac_a   = ACC_W'(r_dx);
                w_mac_b   = XW'(w_hmag);
            end
            ST_DOT_Y: begin
                w_hneg    = -r_hy;
                w_hmag    = r_hy[HW-1] ? w_hneg : r_hy;
                w_mac_req = '{go: !r_run, clr: 1'b0, neg: r_hy[HW-1], nbits: WT_BITS};
                w_mac_a   = ACC_W'(r_dy);
                w_mac_b   = XW'(w_hmag);
            end
            ST_DIV: w_div_go = !r_run && (r_norm != '0);
            ST_SC_DIR: begin
                w_mac_req = '{go: !r_run, clr: 1'b1, neg: 1'b0, nbits: WT_BITS};
                w_mac_a   = ACC_W'(r_cos) <<< 2;
                w_mac_b   = XW'(r_dir_w);
            end
            ST_SC_DIST: begin
                w_mac_req = '{go: !r_run, clr: 1'b0, neg: 1'b1, nbits: WT_BITS};
                w_mac_a   = ACC_W'(r_norm);
                w_mac_b   = XW'(r_dist_w);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_run = r_run;
        if (w_mac_req.go || w_sqrt_go || w_div_go) begin
            n_run = 1'b1;
        end else if (w_mac_done || w_sqrt_done || w_div_done) begin
            n_run = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_run       <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            if (o_goal.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_UPD && w_upd_best) begin
                r_have <= 1'b1;
            end
            if (r_state == ST_EMIT && w_emit_ok) begin
                r_out_valid <= 1'b1;
                r_have      <= 1'b0;
                if (r_have) begin
                    r_prev_x <= r_bx;
                    r_prev_y <= r_by;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fx   <= w_fx;
            r_fy   <= w_fy;
            r_dx   <= {w_fx[XW-1], w_fx} - {w_rx[XW-1], w_rx};
            r_dy   <= {w_fy[XW-1], w_fy} - {w_ry[XW-1], w_ry};
            r_fdx  <= {w_fx[XW-1], w_fx} - {r_prev_x[XW-1], r_prev_x};
            r_fdy  <= {w_fy[XW-1], w_fy} - {r_prev_y[XW-1], r_prev_y};
            r_hx   <= i_frontier.data.heading_x;
            r_hy   <= i_frontier.data.heading_y;
            r_last <= i_frontier.data.last_frontier;
            r_skip <= 1'b0;
        end
        if (r_state == ST_TOL && w_mac_done) begin
            r_tolsq <= w_acc[2*XW-1:0];
        end
        if (r_state == ST_FILT) begin
            r_skip <= w_skip_now;
        end
        if (r_state == ST_SQRT && w_sqrt_done) begin
            r_norm <= w_root;
        end
        if (r_state == ST_DOT_Y && w_mac_done) begin
            r_dot <= w_acc[DOT_W-1:0];
        end
        if (r_state == ST_DIV) begin
            if (r_norm == '0) begin
                r_cos <= '0;
            end else if (w_div_done) begin
                // truncate toward zero: sign follows the dot product
                r_cos <= r_dot[DOT_W-1] ? -COS_W'(w_quo) : COS_W'(w_quo);
            end
        end
        if (r_state == ST_SC_DIST && w_mac_done) begin
            r_score <= w_acc[SCORE_W-1:0];
        end
        if (r_state == ST_UPD && w_upd_best) begin
            r_best <= r_score;
            r_bx   <= r_fx;
            r_by   <= r_fy;
        end
        if (r_state == ST_EMIT && w_emit_ok) begin
            r_goal_found <= r_have;
            r_goal_x     <= r_have ? r_bx : '0;
            r_goal_y     <= r_have ? r_by : '0;
        end
    end

    assign o_goal.valid           = r_out_valid;
    assign o_goal.data.goal_found = r_goal_found;
    assign o_goal.data.goal_x     = r_goal_x;
    assign o_goal.data.goal_y     = r_goal_y;

    fgs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mac_req),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc),
        .o_done  (w_mac_done)
    );

    fgs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_sqrt_go),
        .i_val   (w_acc[2*XW:0]),
        .o_root  (w_root),
        .o_done  (w_sqrt_done)
    );

    fgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_div_go),
        .i_num   (w_dot_mag),
        .i_den   (r_norm),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

endmodule

[hw/rtl/fgs_mac.sv]
// Shift-add multiply-accumulate, one multiplier bit per cycle.
module fgs_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fgs_pkg::t_mac_req                      i_req,
    input  logic signed [fgs_pkg::ACC_W-1:0]       i_a,
    input  logic        [fgs_pkg::XW-1:0]          i_b,
    output logic signed [fgs_pkg::ACC_W-1:0]       o_acc,
    output logic                                   o_done
);
    import fgs_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_a;
    logic [XW-1:0]           r_b;
    logic                    r_neg;
    logic signed [ACC_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_neg <= i_req.neg;
            r_cnt <= i_req.nbits;
            if (i_req.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_neg ? r_acc - r_a : r_acc + r_a;
            end
            r_a   <= r_a <<< 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

[hw/rtl/fgs_sqrt.sv]
// Floor square root, one bit pair per cycle.
module fgs_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [2*fgs_pkg::XW:0]      i_val,
    output logic [fgs_pkg::NORM_W-1:0]  o_root,
    output logic                        o_done
);
    import fgs_pkg::*;

    localparam int VAL_W = 2 * NORM_W;
    localparam int REM_W = NORM_W + 3;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [VAL_W-1:0]    r_val;
    logic [REM_W-3:0]    r_rem;
    logic [NORM_W-1:0]   r_root;

    logic [REM_W-1:0]    w_rem_s;
    logic [REM_W-1:0]    w_trial;
    logic [REM_W-1:0]    w_diff;
    logic                w_ge;

    assign w_rem_s = {r_rem, r_val[VAL_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_rem_s >= w_trial);
    assign w_diff  = w_rem_s - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_val  <= VAL_W'(i_val);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(NORM_W);
        end else if (r_busy) begin
            r_val  <= r_val << 2;
            r_rem  <= w_ge ? w_diff[REM_W-3:0] : w_rem_s[REM_W-3:0];
            r_root <= {r_root[NORM_W-2:0], w_ge};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

[hw/rtl/fgs_div.sv]
// Restoring divider, one quotient bit per cycle.
module fgs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [fgs_pkg::DOT_W-1:0]   i_num,
    input  logic [fgs_pkg::NORM_W-1:0]  i_den,
    output logic [fgs_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_done
);
    import fgs_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DOT_W-1:0]    r_num;
    logic [QUO_W-1:0]    r_q;
    logic [NORM_W-1:0]   r_den;
    logic [NORM_W-1:0]   r_rem;

    logic [NORM_W:0]     w_rem_s;
    logic [NORM_W:0]     w_diff;
    logic                w_ge;

    assign w_rem_s = {r_rem, r_num[DOT_W-1]};
    assign w_ge    = (w_rem_s >= {1'b0, r_den});
    assign w_diff  = w_rem_s - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // the quotient never exceeds QUO_W bits, so only those are kept
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= CNT_W'(DOT_W);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_ge ? w_diff[NORM_W-1:0] : w_rem_s[NORM_W-1:0];
            r_q   <= {r_q[QUO_W-2:0], w_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;

endmodule

[hw/rtl/fgs_checker.sv]
module fgs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_found,
    input logic [31:0] i_out_x,
    input logic [31:0] i_out_y
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_found) |-> (i_out_x == 32'd0 && i_out_y == 32'd0))
        else $error("goal coordinates nonzero without a goal");

    // one item at a time: an input transfer closes the input side
    a_one_item: assert property (@(posedge i_clk)
        (i_rst_n && i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second item taken while busy");

endmodule

bind frontier_goal_select fgs_checker u_fgs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_frontier.valid),
    .i_in_ready  (i_frontier.ready),
    .i_out_valid (o_goal.valid),
    .i_out_ready (o_goal.ready),
    .i_out_found (o_goal.data.goal_found),
    .i_out_x     (o_goal.data.goal_x),
    .i_out_y     (o_goal.data.goal_y)
);

[dv/frontier_goal_select_test.sv]
module frontier_goal_select_test;
    import fgs_pkg::*;

    // Expected goals per batch, plus a private copy of the selector state.
    class goal_board;
        t_goal  goal_q[$];
        int     errors;
        longint dist_w, dir_w, filt_on, tol;
        longint prev_x, prev_y, best_score, best_x, best_y;
        bit     have_best;

        function new();
            dist_w = 256; dir_w = 0; filt_on = 1; tol = 32768;
            prev_x = 0; prev_y = 0;
            clear_batch();
        endfunction

        function void clear_batch();
            best_score = 64'sh8000_0000_0000_0000;
            best_x = 0; best_y = 0; have_best = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                CFG_DIST_W:  dist_w = longint'(v[15:0]);
                CFG_DIR_W:   dir_w = longint'(v[15:0]);
                CFG_FILT_ON: filt_on = longint'(v[0]);
                CFG_TOL:     tol = longint'(v);
                default: ;
            endcase
        endfunction

        function logic [65:0] sq_sum(longint a, longint b);
            logic [65:0] ua, ub;
            ua = (a < 0) ? 66'(-a) : 66'(a);
            ub = (b < 0) ? 66'(-b) : 66'(b);
            return ua * ua + ub * ub;
        endfunction

        // bit-pair floor square root
        function longint root66(logic [65:0] v);
            logic [67:0] rem, root, trial;
            rem = 0;
            root = 0;
            for (int i = 32; i >= 0; i--) begin
                rem = (rem << 2) | 68'(v[2*i+1 -: 2]);
                trial = (root << 2) | 68'd1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = (root << 1) | 68'd1;
                end else begin
                    root = root << 1;
                end
            end
            return longint'(root[63:0]);
        endfunction

        function void note_frontier(t_frontier f);
            longint fx, fy, dx, dy, norm, dot, cosv, score;
            logic [63:0] tt;
            t_goal g;
            bit drop;
            fx = longint'(f.frontier_x);
            fy = longint'(f.frontier_y);
            drop = 0;
            if (filt_on != 0) begin
                tt = 64'(tol) * 64'(tol);
                drop = sq_sum(fx - prev_x, fy - prev_y) < {2'b00, tt};
            end
            if (!drop) begin
                dx = fx - longint'(f.robot_x);
                dy = fy - longint'(f.robot_y);
                norm = root66(sq_sum(dx, dy));
                dot = dx * longint'(f.heading_x) + dy * longint'(f.heading_y);
                cosv = (norm != 0) ? dot / norm : 0;
                score = dir_w * cosv * 4 - dist_w * norm;
                if (!have_best || score > best_score) begin
                    best_score = score;
                    best_x = fx;
                    best_y = fy;
                    have_best = 1;
                end
            end
            if (f.last_frontier) begin
                g.goal_found = have_best;
                g.goal_x = have_best ? best_x[31:0] : '0;
                g.goal_y = have_best ? best_y[31:0] : '0;
                if (have_best) begin
                    prev_x = best_x;
                    prev_y = best_y;
                end
                goal_q.push_back(g);
                clear_batch();
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_goal(t_goal got);
            t_goal w;
            if (goal_q.size() == 0) begin
                report($sformatf("unexpected goal %0d %h %h",
                    got.goal_found, got.goal_x, got.goal_y));
                return;
            end
            w = goal_q.pop_front();
            if (got.goal_found !== w.goal_found)
                report($sformatf("found %0d want %0d", got.goal_found, w.goal_found));
            if (got.goal_x !== w.goal_x)
                report($sformatf("goal_x %h want %h", got.goal_x, w.goal_x));
            if (got.goal_y !== w.goal_y)
                report($sformatf("goal_y %h want %h", got.goal_y, w.goal_y));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    bit          steady;     // no idling on either side while set
    goal_board   board;

    fgs_stream_if #(.T(t_frontier)) frontier_if ();
    fgs_stream_if #(.T(t_goal))     goal_if ();

    frontier_goal_select u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frontier (frontier_if.sink),
        .o_goal     (goal_if.source)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("frontier_goal_select_test NOT OK");
        $finish;
    end

    // result side: random stalls, checked on every transfer
    initial begin
        goal_if.ready = 0;
        forever begin
            @(negedge i_clk);
            goal_if.ready <= steady || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && goal_if.valid && goal_if.ready)
            board.check_goal(goal_if.data);
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        board.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic send(t_frontier f);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 34) begin
            frontier_if.valid <= 0;
            @(negedge i_clk);
        end
        frontier_if.valid <= 1;
        frontier_if.data <= f;
        do @(posedge i_clk); while (!frontier_if.ready);
        board.note_frontier(f);
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        frontier_if.valid <= 0;
    endtask

    // blocks go quiet only after their batch end has come back
    task automatic drain();
        release_bus();
        while (board.goal_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    function automatic t_frontier make(logic [31:0] fx, logic [31:0] fy,
                                       logic [31:0] rx, logic [31:0] ry,
                                       logic [15:0] hx, logic [15:0] hy, logic last);
        t_frontier f;
        f.frontier_x = fx; f.frontier_y = fy;
        f.robot_x = rx; f.robot_y = ry;
        f.heading_x = hx; f.heading_y = hy;
        f.last_frontier = last;
        return f;
    endfunction

    function automatic logic [31:0] near(logic [31:0] base);
        case ($urandom_range(3))
            0: return $urandom();
            1: return base + 32'($urandom_range(20000)) - 32'd10000;
            2: return base + 32'($urandom_range(2000000)) - 32'd1000000;
            default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_heading();
        case ($urandom_range(5))
            0: return 16'($urandom());
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($urandom_range(32768)) - 16'd16384;
        endcase
    endfunction

    task automatic random_batches(int items);
        int          n, len;
        logic [31:0] rx, ry, fx, fy;
        logic [15:0] hx, hy;
        n = 0;
        while (n < items) begin
            len = $urandom_range(8, 1);
            rx = $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(1 << 22));
            ry = $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(1 << 22));
            hx = pick_heading();
            hy = pick_heading();
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(5) == 0) begin
                    // close to the last goal to hit the exclusion circle
                    fx = 32'(board.prev_x) + 32'($urandom_range(65536)) - 32'd32768;
                    fy = 32'(board.prev_y) + 32'($urandom_range(65536)) - 32'd32768;
                end else if ($urandom_range(9) == 0) begin
                    fx = rx;
                    fy = ry;
                end else begin
                    fx = near(rx);
                    fy = near(ry);
                end
                if ($urandom_range(9) == 0) begin
                    hx = pick_heading();
                    hy = pick_heading();
                end
                send(make(fx, fy, rx, ry, hx, hy, k == len - 1));
                n++;
                steady = (n > items / 3 && n < items / 2);
            end
        end
        steady = 0;
    endtask

    initial begin
        board = new();
        steady = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_DIST_W;
        i_cfg_data = 0;
        frontier_if.valid = 0;
        frontier_if.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // defaults: distance only, filter around the origin
        send(make(32'h0000_4000, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 1));
        send(make(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 0));
        send(make(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 1));
        send(make(32'h0001_0000, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 1));
        drain();

        write_reg(CFG_DIST_W, 32'd0);
        write_reg(CFG_DIR_W, 32'hffff);
        write_reg(CFG_FILT_ON, 32'd0);
        send(make(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  -16'sd16384, 16'sd16384, 0));
        send(make(32'h1234, 32'h5678, 32'h1234, 32'h5678, 16'sd16384, 16'sd0, 0));
        send(make(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  16'h8000, 16'h7fff, 0));
        send(make(32'h0002_0000, 32'h0, 32'h0, 32'h0, 16'h7fff, 16'h8000, 1));
        send(make(32'h0002_0000, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 0));
        send(make(32'h0002_0000, 32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd0, 1));
        drain();

        write_reg(CFG_FILT_ON, 32'd1);
        write_reg(CFG_TOL, 32'hffff_ffff);
        send(make(32'h0003_0000, 32'h0, 32'h0, 32'h0, 16'sd0, 16'sd16384, 1));
        send(make(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 16'sd0, 16'sd16384, 1));
        drain();
        write_reg(CFG_TOL, 32'd0);
        send(make(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0, 16'sd0, 16'sd16384, 1));
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: ;
                1: write_reg(CFG_DIST_W, 32'hffff);
                2: write_reg(CFG_DIR_W, 32'd0);
                3: write_reg(CFG_TOL, 32'h0001_0000);
                4: write_reg(CFG_FILT_ON, 32'd0);
                default: begin
                    write_reg(CFG_DIST_W, $urandom_range(65535));
                    write_reg(CFG_DIR_W, $urandom_range(65535));
                    write_reg(CFG_FILT_ON, 32'd1);
                    write_reg(CFG_TOL, $urandom_range(1 << 20));
                end
            endcase
            random_batches(p == 5 ? 600 : 260);
            drain();
        end

        if (board.errors == 0 && board.goal_q.size() == 0) begin
            $display("frontier_goal_select_test OK");
        end else begin
            $display("frontier_goal_select_test NOT OK");
        end
        $finish;
    end

endmodule
